>>> hdl/kpi_pkg.sv
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared types and constants for the keyframe parameter interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

    localparam int TIME_W = 40;
    localparam int VAL_W  = 32;
    localparam int DT_W   = 17;
    localparam int ACC_W  = 40;
    localparam int PROD_W = 58;

    localparam logic [DT_W-1:0]   ONE_Q16    = 17'd65536;
    localparam logic [DT_W-1:0]   STEP_LIMIT = 17'd65530;
    localparam logic [17:0]       RATE_RESET = 18'd48000;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;

    // segment modes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_GAP    = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;
    localparam logic [1:0] MODE_CUBIC  = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]       ktime;
        logic signed [VAL_W-1:0] kval;
        logic [1:0]              kmode;
    } key_entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_MUL,
        S_ADD_TIME,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_PREV_RD,
        S_PREV_GET,
        S_P0_RD,
        S_P0_GET,
        S_P3_RD,
        S_P3_GET,
        S_DIV,
        S_COEF,
        S_MUL,
        S_ACC,
        S_FINAL,
        S_TICK_END,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DONE
    } state_t;

endpackage

>>> hdl/keyframe_parameter_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_parameter_interpolator
// Keyframe automation for one parameter: sorted keyframe store, per-sample
// linear / gap / step / Catmull-Rom evaluation.
// ----------------------------------------------------------------------------
// One request at a time; each gives one result. A set-now or unused request,
// like an add request that finds the store full, goes straight to hand-over.
// An add request compares the keyframes in turn through the single read port
// of the keyframe memory to find the slot, then moves each later keyframe up
// by one. A tick searches for the current sample, fetches the neighbours,
// runs the restoring divider for dt (unless both neighbours share a time),
// dispatches on the mode, makes passes of the shared multiplier and
// finishes (one pass for linear, three for cubic, none for gap and step),
// then frees, advances and hands over; outside a segment it goes from the
// search straight to freeing and advancing. A finished request waits in
// S_DONE while the previous result is held back by out_ready. Keyframes sit
// in a circular buffer, so freeing the oldest one costs nothing. The user
// must see that the sample rate register is written through the cfg channel
// only while idle; the block itself does not enforce it.
module keyframe_parameter_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [17:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [31:0]         delay_time,
    input  logic signed [31:0]  new_value,
    input  logic [1:0]          interp_mode,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  param_value,
    output logic                in_segment,
    output logic                store_full
);
    import kpi_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    // keyframe memory
    key_entry_t mem [MAX_KEYS];
    key_entry_t rd_q;
    logic [CW-1:0] rd_l, wr_l;
    logic [AW-1:0] rd_phys, wr_phys;
    logic [AW:0]   rd_sum, wr_sum;
    logic          wr_en;
    key_entry_t    wr_data;

    state_t state_reg, state_next;
    logic [17:0]  rate_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] k_reg, k_next;
    logic [TIME_W-1:0] counter_reg, counter_next;
    logic signed [31:0] held_reg, held_next;
    logic seg_reg, seg_next, full_reg, full_next;
    logic [1:0] op_reg, op_next;
    logic [31:0] delay_reg, delay_next;
    logic signed [31:0] nval_reg, nval_next;
    logic [1:0] nmode_reg, nmode_next;
    logic [TIME_W-1:0] tgt_reg, tgt_next;
    logic [49:0] rprod_reg, rprod_next;
    logic [TIME_W-1:0] prev_t_reg, prev_t_next, curr_t_reg, curr_t_next;
    logic signed [31:0] pv_reg, pv_next, cv_reg, cv_next;
    logic signed [31:0] p0_reg, p0_next, p3_reg, p3_next;
    logic [1:0] cmode_reg, cmode_next;
    logic [TIME_W:0] rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [DT_W-1:0] dt_reg, dt_next;
    logic [4:0] dcnt_reg, dcnt_next;
    logic signed [ACC_W-1:0] first_reg, first_next, acc_reg, acc_next;
    logic signed [ACC_W-1:0] b_reg, b_next, c_reg, c_next;
    logic [1:0] round_reg, round_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic out_seg_reg, out_seg_next, out_full_reg, out_full_next;

    // arithmetic helpers
    logic signed [ACC_W-1:0] mul_op, rs_val, addend, half_v;
    logic signed [PROD_W-1:0] mul_res, rnd;
    logic signed [ACC_W-1:0] p0e, p1e, p2e, p3e;
    logic [TIME_W:0] rem_sub;
    logic div_ge;

    // circular address mapping
    always_comb
    begin
        rd_sum  = {1'b0, head_reg} + (AW+1)'(rd_l);
        wr_sum  = {1'b0, head_reg} + (AW+1)'(wr_l);
        rd_phys = (rd_sum >= (AW+1)'(MAX_KEYS)) ? AW'(rd_sum - (AW+1)'(MAX_KEYS))
                                                 : AW'(rd_sum);
        wr_phys = (wr_sum >= (AW+1)'(MAX_KEYS)) ? AW'(wr_sum - (AW+1)'(MAX_KEYS))
                                                 : AW'(wr_sum);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_phys] <= wr_data;
        end
        rd_q <= mem[rd_phys];
    end

    // shared multiplier and rounding
    assign mul_op  = (round_reg == 2'd0) ? first_reg : acc_reg;
    assign mul_res = mul_op * $signed({1'b0, dt_reg});
    assign rnd     = prod_reg + 58'sd32768;
    assign rs_val  = rnd[55:16];
    assign half_v  = (acc_reg + 40'sd1) >>> 1;

    always_comb
    begin
        case (round_reg)
            2'd0:    addend = (cmode_reg == MODE_CUBIC) ? b_reg : 40'(pv_reg);
            2'd1:    addend = c_reg;
            default: addend = 40'(pv_reg) <<< 1;
        endcase
    end

    assign p0e = 40'(p0_reg);
    assign p1e = 40'(pv_reg);
    assign p2e = 40'(cv_reg);
    assign p3e = 40'(p3_reg);

    // divider step
    assign div_ge  = rem_reg >= {1'b0, den_reg};
    assign rem_sub = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= RATE_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            counter_reg   <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            counter_reg   <= counter_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                rate_reg <= cfg_data;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        seg_reg      <= seg_next;
        full_reg     <= full_next;
        op_reg       <= op_next;
        delay_reg    <= delay_next;
        nval_reg     <= nval_next;
        nmode_reg    <= nmode_next;
        tgt_reg      <= tgt_next;
        rprod_reg    <= rprod_next;
        prev_t_reg   <= prev_t_next;
        curr_t_reg   <= curr_t_next;
        pv_reg       <= pv_next;
        cv_reg       <= cv_next;
        p0_reg       <= p0_next;
        p3_reg       <= p3_next;
        cmode_reg    <= cmode_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        dt_reg       <= dt_next;
        dcnt_reg     <= dcnt_next;
        first_reg    <= first_next;
        acc_reg      <= acc_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        round_reg    <= round_next;
        prod_reg     <= prod_next;
        out_val_reg  <= out_val_next;
        out_seg_reg  <= out_seg_next;
        out_full_reg <= out_full_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        counter_next   = counter_reg;
        held_next      = held_reg;
        seg_next       = seg_reg;
        full_next      = full_reg;
        op_next        = op_reg;
        delay_next     = delay_reg;
        nval_next      = nval_reg;
        nmode_next     = nmode_reg;
        tgt_next       = tgt_reg;
        rprod_next     = rprod_reg;
        prev_t_next    = prev_t_reg;
        curr_t_next    = curr_t_reg;
        pv_next        = pv_reg;
        cv_next        = cv_reg;
        p0_next        = p0_reg;
        p3_next        = p3_reg;
        cmode_next     = cmode_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dt_next        = dt_reg;
        dcnt_next      = dcnt_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        round_next     = round_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_val_next   = out_val_reg;
        out_seg_next   = out_seg_reg;
        out_full_next  = out_full_reg;
        rd_l           = '0;
        wr_l           = '0;
        wr_en          = 1'b0;
        wr_data        = rd_q;
        in_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = cmd;
                    delay_next = delay_time;
                    nval_next  = new_value;
                    nmode_next = interp_mode;
                    seg_next   = 1'b0;
                    full_next  = 1'b0;
                    idx_next   = '0;
                    tgt_next   = counter_reg;
                    state_next = S_DONE;
                    if (cmd == CMD_TICK)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (cmd == CMD_ADD)
                    begin
                        if (count_reg == CW'(MAX_KEYS))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_ADD_MUL;
                        end
                    end
                    else if (cmd == CMD_SET)
                    begin
                        held_next = new_value;
                    end
                end
            end

            // keyframe time from delay
            S_ADD_MUL:
            begin
                rprod_next = rate_reg * delay_reg;
                state_next = S_ADD_TIME;
            end

            S_ADD_TIME:
            begin
                tgt_next   = counter_reg + TIME_W'(rprod_reg[49:16]);
                state_next = S_SCAN_RD;
            end

            // search for the first keyframe at or after the target time
            S_SCAN_RD:
            begin
                rd_l = idx_reg;
                if (idx_reg == count_reg)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (rd_q.ktime < tgt_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    curr_t_next = rd_q.ktime;
                    cv_next     = rd_q.kval;
                    p3_next     = rd_q.kval;
                    cmode_next  = rd_q.kmode;
                    state_next  = S_SCAN_END;
                end
            end

            S_SCAN_END:
            begin
                if (op_reg == CMD_ADD)
                begin
                    k_next     = count_reg;
                    state_next = S_INS_RD;
                end
                else if (idx_reg != '0 && idx_reg < count_reg)
                begin
                    state_next = S_PREV_RD;
                end
                else
                begin
                    state_next = S_TICK_END;
                end
            end

            // fetch neighbours
            S_PREV_RD:
            begin
                rd_l       = idx_reg - 1'b1;
                state_next = S_PREV_GET;
            end

            S_PREV_GET:
            begin
                prev_t_next = rd_q.ktime;
                pv_next     = rd_q.kval;
                p0_next     = rd_q.kval;
                state_next  = S_P0_RD;
            end

            S_P0_RD:
            begin
                rd_l       = (idx_reg >= CW'(2)) ? idx_reg - CW'(2) : '0;
                state_next = S_P0_GET;
            end

            S_P0_GET:
            begin
                if (idx_reg >= CW'(2))
                begin
                    p0_next = rd_q.kval;
                end
                state_next = S_P3_RD;
            end

            S_P3_RD:
            begin
                rd_l       = (idx_reg + 1'b1 < count_reg) ? idx_reg + 1'b1 : '0;
                state_next = S_P3_GET;
            end

            S_P3_GET:
            begin
                if (idx_reg + 1'b1 < count_reg)
                begin
                    p3_next = rd_q.kval;
                end
                den_next  = curr_t_reg - prev_t_reg;
                rem_next  = {1'b0, tgt_reg - prev_t_reg};
                dt_next   = '0;
                dcnt_next = '0;
                if (curr_t_reg == prev_t_reg)
                begin
                    dt_next    = ONE_Q16;
                    state_next = S_COEF;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            // restoring divider, one quotient bit a cycle
            S_DIV:
            begin
                rem_next  = {rem_sub[TIME_W-1:0], 1'b0};
                dt_next   = {dt_reg[DT_W-2:0], div_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'd16)
                begin
                    state_next = S_COEF;
                end
            end

            // mode dispatch and cubic coefficients
            S_COEF:
            begin
                round_next = 2'd0;
                case (cmode_reg)
                    MODE_LINEAR:
                    begin
                        first_next = p2e - p1e;
                        state_next = S_MUL;
                    end
                    MODE_GAP:
                    begin
                        held_next  = '0;
                        seg_next   = 1'b1;
                        state_next = S_TICK_END;
                    end
                    MODE_STEP:
                    begin
                        held_next  = (dt_reg < STEP_LIMIT) ? pv_reg : cv_reg;
                        seg_next   = 1'b1;
                        state_next = S_TICK_END;
                    end
                    default:
                    begin
                        first_next = p3e - p0e + (p1e <<< 1) + p1e
                                     - (p2e <<< 1) - p2e;
                        b_next     = (p0e <<< 1) - (p1e <<< 2) - p1e
                                     + (p2e <<< 2) - p3e;
                        c_next     = p2e - p0e;
                        state_next = S_MUL;
                    end
                endcase
            end

            S_MUL:
            begin
                prod_next  = mul_res;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next   = rs_val + addend;
                round_next = round_reg + 1'b1;
                if (cmode_reg != MODE_CUBIC || round_reg == 2'd2)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_FINAL:
            begin
                seg_next = 1'b1;
                if (cmode_reg != MODE_CUBIC)
                begin
                    held_next = acc_reg[31:0];
                end
                else if (half_v > 40'sd2147483647)
                begin
                    held_next = 32'sh7fffffff;
                end
                else if (half_v < -40'sd2147483648)
                begin
                    held_next = 32'sh80000000;
                end
                else
                begin
                    held_next = half_v[31:0];
                end
                state_next = S_TICK_END;
            end

            // free the oldest keyframe once three precede the sample, and advance the counter
            S_TICK_END:
            begin
                if (idx_reg >= CW'(3))
                begin
                    head_next  = (head_reg == AW'(MAX_KEYS - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                counter_next = counter_reg + 1'b1;
                state_next   = S_DONE;
            end

            // open a slot by moving later keyframes up
            S_INS_RD:
            begin
                rd_l = k_reg - 1'b1;
                if (k_reg == idx_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_l       = k_reg;
                wr_data    = rd_q;
                k_next     = k_reg - 1'b1;
                state_next = S_INS_RD;
            end

            S_INS_PUT:
            begin
                wr_en         = 1'b1;
                wr_l          = idx_reg;
                wr_data.ktime = tgt_reg;
                wr_data.kval  = nval_reg;
                wr_data.kmode = nmode_reg;
                count_next    = count_reg + 1'b1;
                state_next    = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = held_reg;
                    out_seg_next   = seg_reg;
                    out_full_next  = full_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign param_value = out_val_reg;
    assign in_segment  = out_seg_reg;
    assign store_full  = out_full_reg;

endmodule

>>> hdl/kpi_checker.sv
// ----------------------------------------------------------------------------
// kpi_checker
// Port-level checks for the keyframe parameter interpolator.
// ----------------------------------------------------------------------------
module kpi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] param_value,
    input logic               in_segment,
    input logic               store_full
);

    // a result never claims both a new value and a dropped keyframe
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_segment && store_full))
        else $error("in_segment and store_full both set");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(param_value)
                                       && $stable(in_segment) && $stable(store_full)))
        else $error("stalled result changed");

endmodule

bind keyframe_parameter_interpolator kpi_checker u_kpi_checker (.*);

>>> tb/kpi_automation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_automation_checker
// Watches the cfg, request and result channels of the keyframe interpolator,
// keeps its own keyframe store, sample counter and held value, works out the
// result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module kpi_automation_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [17:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [31:0]        delay_time,
    input  logic signed [31:0] new_value,
    input  logic [1:0]         interp_mode,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] param_value,
    input  logic               in_segment,
    input  logic               store_full,
    output int                 errors,
    output int                 pending
);
    import kpi_pkg::*;

    localparam int KEYS = 16;

    typedef struct {
        logic signed [31:0] value;
        logic               seg;
        logic               full;
    } param_result_t;

    param_result_t     expected_results[$];

    logic [TIME_W-1:0] key_t [KEYS];
    longint            key_v [KEYS];
    logic [1:0]        key_m [KEYS];
    int                key_cnt;
    logic [TIME_W-1:0] now_ctr;
    logic signed [31:0] held;
    logic [17:0]       rate;

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint rnd16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // catmull-rom through four values, horner form with rounded shifts
    function automatic longint spline(input longint dt, input longint p0, input longint p1,
                                      input longint p2, input longint p3);
        longint a, b, c, acc;
        a   = -p0 + 3 * p1 - 3 * p2 + p3;
        b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c   = p2 - p0;
        acc = rnd16(a * dt) + b;
        acc = rnd16(acc * dt) + c;
        acc = rnd16(acc * dt) + 2 * p1;
        acc = (acc + 1) >>> 1;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc;
    endfunction

    // one sample: evaluate the segment around now, free the oldest key once three precede now, advance
    function automatic logic eval_tick();
        int          i;
        logic        hit;
        longint      pv, cv, dt, p0, p3;
        logic [63:0] num, den;
        i   = 0;
        hit = 1'b0;
        while (i < key_cnt && key_t[i] < now_ctr)
            i++;
        if (i > 0 && i < key_cnt) begin
            pv  = key_v[i-1];
            cv  = key_v[i];
            dt  = 65536;
            den = 64'(key_t[i]) - 64'(key_t[i-1]);
            num = (64'(now_ctr) - 64'(key_t[i-1])) << 16;
            if (den != 0)
                dt = longint'(num / den);
            case (key_m[i])
                MODE_LINEAR: held = 32'(pv + rnd16((cv - pv) * dt));
                MODE_GAP:    held = '0;
                MODE_STEP:   held = 32'((dt < 65530) ? pv : cv);
                default:
                begin
                    p0   = (i >= 2) ? key_v[i-2] : pv;
                    p3   = (i + 1 < key_cnt) ? key_v[i+1] : cv;
                    held = 32'(spline(dt, p0, pv, cv, p3));
                end
            endcase
            hit = 1'b1;
        end
        if (i >= 3) begin
            for (int k = 1; k < key_cnt; k++) begin
                key_t[k-1] = key_t[k];
                key_v[k-1] = key_v[k];
                key_m[k-1] = key_m[k];
            end
            key_cnt--;
        end
        now_ctr = now_ctr + 1'b1;
        return hit;
    endfunction

    // sorted insert, returns 1 when dropped for lack of room
    function automatic logic insert_key(input logic [31:0] dly, input logic signed [31:0] v,
                                        input logic [1:0] m);
        logic [TIME_W-1:0] t;
        logic [63:0]       prod;
        int                pos;
        if (key_cnt >= KEYS)
            return 1'b1;
        prod = 64'(rate) * 64'(dly);
        t    = now_ctr + TIME_W'(prod >> 16);
        pos  = 0;
        while (pos < key_cnt && key_t[pos] < t)
            pos++;
        for (int k = key_cnt; k > pos; k--) begin
            key_t[k] = key_t[k-1];
            key_v[k] = key_v[k-1];
            key_m[k] = key_m[k-1];
        end
        key_t[pos] = t;
        key_v[pos] = longint'(v);
        key_m[pos] = m;
        key_cnt++;
        return 1'b0;
    endfunction

    // predict on requests, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        param_result_t r, e;
        if (!rst_n) begin
            expected_results.delete();
            key_cnt = 0;
            now_ctr = '0;
            held    = '0;
            rate    = RATE_RESET;
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                rate = cfg_data;
            if (in_valid && in_ready) begin
                r.seg  = 1'b0;
                r.full = 1'b0;
                if (cmd == CMD_TICK)
                    r.seg = eval_tick();
                else if (cmd == CMD_ADD)
                    r.full = insert_key(delay_time, new_value, interp_mode);
                else if (cmd == CMD_SET)
                    held = new_value;
                r.value = held;
                expected_results.push_back(r);
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("[%0t] result with no request waiting", $realtime);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (param_value !== e.value)
                        report("param_value", longint'(param_value), longint'(e.value));
                    if (in_segment !== e.seg)
                        report("in_segment", longint'(in_segment), longint'(e.seg));
                    if (store_full !== e.full)
                        report("store_full", longint'(store_full), longint'(e.full));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/keyframe_parameter_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_parameter_interpolator_tb
// Drives tick, add-keyframe, set-now and unused requests in bursts through several
// sample rates, with a stalling result side, and lets the checker judge.
// ----------------------------------------------------------------------------
module keyframe_parameter_interpolator_tb;
    import kpi_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         ITEM_GOAL = 650;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [17:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [31:0]        delay_time;
    logic signed [31:0] new_value;
    logic [1:0]         interp_mode;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] param_value;
    logic               in_segment;
    logic               store_full;
    int                 errors;
    int                 pending;

    int                 sent;
    int                 burst_left;
    int                 cycles;
    logic [17:0]        cur_rate;
    logic               hold_request;

    keyframe_parameter_interpolator #(.MAX_KEYS(16)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .delay_time(delay_time),
        .new_value(new_value), .interp_mode(interp_mode),
        .out_valid(out_valid), .out_ready(out_ready), .param_value(param_value),
        .in_segment(in_segment), .store_full(store_full)
    );

    kpi_automation_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .delay_time(delay_time),
        .new_value(new_value), .interp_mode(interp_mode),
        .out_valid(out_valid), .out_ready(out_ready), .param_value(param_value),
        .in_segment(in_segment), .store_full(store_full),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side: changing stall patterns plus one long hold-off
    initial
    begin
        int k;
        int style;
        logic held_off;
        k        = 0;
        style    = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request && !held_off) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            k++;
            if (k % 150 == 0)
                style = $urandom_range(0, 3);
            case (style)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (k % 4 != 0);
                default: out_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // one request, called at a rising edge, returns at the accepting edge or, at the end of a burst, after a random gap
    task automatic send_req(input logic [1:0] c, input logic [31:0] d,
                            input logic [31:0] v, input logic [1:0] m);
        int gap;
        in_valid    <= 1'b1;
        cmd         <= c;
        delay_time  <= d;
        new_value   <= v;
        interp_mode <= m;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 12);
        end
    endtask

    // delay in Q16.16 seconds that lands roughly the given number of samples ahead
    function automatic logic [31:0] delay_for(input int samples);
        if (cur_rate == 0)
            return $urandom;
        return 32'((longint'(samples) * 65536) / cur_rate + $urandom_range(0, 65536 / cur_rate));
    endfunction

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return 32'(($urandom_range(0, 2000) - 1000) * 256);
    endfunction

    task automatic add_key(input int samples, input logic [31:0] v, input logic [1:0] m);
        send_req(CMD_ADD, delay_for(samples), v, m);
    endtask

    task automatic ticks(input int n);
        repeat (n) send_req(CMD_TICK, $urandom, $urandom, 2'($urandom_range(0, 3)));
    endtask

    // register write once the request side is idle and all results are back
    task automatic write_rate(input logic [17:0] r);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        cur_rate = r;
    endtask

    // random phase: mostly automation runs, some noise and overfill
    task automatic random_phase(input int n_items);
        int stop;
        int kind;
        stop = sent + n_items;
        while (sent < stop) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                repeat ($urandom_range(2, 5))
                    add_key($urandom_range(0, 12), rand_value(), 2'($urandom_range(0, 3)));
                if ($urandom_range(0, 3) == 0)
                    send_req(CMD_SET, $urandom, rand_value(), 2'($urandom_range(0, 3)));
                ticks($urandom_range(5, 25));
            end else if (kind < 18) begin
                repeat ($urandom_range(3, 10))
                    send_req(2'($urandom_range(0, 3)), delay_for($urandom_range(0, 12)),
                             $urandom, 2'($urandom_range(0, 3)));
            end else begin
                repeat (18)
                    add_key($urandom_range(0, 6), rand_value(), 2'($urandom_range(0, 3)));
                ticks(24);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_TICK;
        delay_time   = '0;
        new_value    = '0;
        interp_mode  = MODE_LINEAR;
        out_ready    = 1'b0;
        hold_request = 1'b0;
        sent         = 0;
        burst_left   = 0;
        cur_rate     = RATE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, value extremes, unused command, every mode
        send_req(CMD_TICK, '0, '0, MODE_LINEAR);
        send_req(CMD_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, MODE_CUBIC);
        send_req(CMD_SET, '0, 32'h8000_0000, MODE_LINEAR);
        send_req(CMD_NONE, 32'hFFFF_FFFF, 32'h1234_5678, MODE_STEP);
        send_req(CMD_TICK, '0, '0, MODE_GAP);
        add_key(0, 32'h8000_0000, MODE_LINEAR);
        add_key(2, 32'h7FFF_FFFF, MODE_CUBIC);
        // keys close together, often at the same time, go in ahead of equal times
        add_key(2, 32'h0001_2345, MODE_STEP);
        add_key(5, 32'h8000_0000, MODE_STEP);
        add_key(8, 32'h7FFF_FFFF, MODE_GAP);
        add_key(10, -32'sd5, MODE_LINEAR);
        ticks(12);

        // rate zero: any delay lands on the current sample, store overfills
        write_rate(18'd0);
        random_phase(110);

        write_rate(18'd1);
        hold_request = 1'b1;
        random_phase(100);
        write_rate(18'd192000);
        random_phase(100);
        write_rate(18'h3FFFF);
        random_phase(100);
        write_rate(18'd44100);
        random_phase(ITEM_GOAL - sent > 50 ? ITEM_GOAL - sent : 50);

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hdl/kpi_pkg.sv
hdl/keyframe_parameter_interpolator.sv
hdl/kpi_checker.sv
tb/kpi_automation_checker.sv
tb/keyframe_parameter_interpolator_tb.sv
